// ----- sv/jls_pkg.sv -----
package jls_pkg;

    localparam int DATA_W         = 32;
    localparam int IDX_W          = 4;
    localparam int CNT_W          = 5;
    localparam int COL_W          = 5;
    localparam int MASK_W         = 16;
    localparam int RES_CAP        = 16;
    localparam int COEF_FRAC      = 30;
    localparam int VAL_FRAC       = 16;
    localparam int DIV_W          = 64;
    localparam int D_W            = 49;
    localparam int PROD_W         = 64;
    localparam int ACC_W          = 68;
    localparam int SUM_W          = 37;
    localparam int XSUM_W         = 50;
    localparam int ITER_W         = 16;
    localparam int TOL_W          = 31;
    localparam int SIZE_W         = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int STAT_W         = 2;
    localparam int DEF_MAX_N      = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(66);
    localparam logic [ITER_W-1:0]  LIMIT_RESET = ITER_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    localparam logic [STAT_W-1:0] RES_CONVERGED   = 2'd0;
    localparam logic [STAT_W-1:0] RES_NO_SOLUTION = 2'd1;
    localparam logic [STAT_W-1:0] RES_LIMIT       = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_RD_W, OP_DOM_ACC, OP_DOM_ROW, OP_SAVE_MASK,
        OP_SW_INIT, OP_SW_CMP, OP_SW_A, OP_SW_B, OP_SW_C, OP_DIAG, OP_DIV_C,
        OP_WR_C, OP_WR_CZ, OP_DIV_D, OP_WR_D, OP_IT_START, OP_IT_RD, OP_IT_MUL,
        OP_IT_ACC, OP_IT_ROW, OP_IT_END
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DOM_RD, ST_DOM_ACC, ST_DOM_ROW, ST_DOM_END, ST_SW_SEL, ST_SW_RD,
        ST_SW_CMP, ST_SW_A, ST_SW_B, ST_SW_C, ST_CF_DRD, ST_CF_DIAG, ST_CF_RD,
        ST_CF_DIV, ST_CF_WAIT, ST_CF_WR, ST_CF_D, ST_CF_DWAIT, ST_CF_DWR, ST_IT_INIT,
        ST_IT_RD, ST_IT_MUL, ST_IT_ACC, ST_IT_ROW, ST_IT_END, ST_IT_CHK, ST_OUT,
        ST_NOSOL
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic [MASK_W-1:0] mask0;
        logic              fail;
        logic              zero_diag;
        logic              div_busy;
        logic              conv;
        logic              lim;
    } t_status;

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

endpackage

// ----- sv/jls_req_if.sv -----
interface jls_req_if;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [3:0]           row_index;
    logic [4:0]           column_index;
    logic signed [31:0]   coefficient;

    modport source(output valid, req_type, row_index, column_index, coefficient,
                   input ready);
    modport sink(input valid, req_type, row_index, column_index, coefficient,
                 output ready);
endinterface

// ----- sv/jls_res_if.sv -----
interface jls_res_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           unknown_index;
    logic signed [31:0]   solution_value;
    logic [1:0]           status;
    logic [15:0]          iteration_count;
    logic                 last_result;

    modport source(output valid, unknown_index, solution_value, status,
                   iteration_count, last_result, input ready);
    modport sink(input valid, unknown_index, solution_value, status,
                 iteration_count, last_result, output ready);
endinterface

// ----- sv/jls_div.sv -----
module jls_div import jls_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    input  logic                     i_coef,
    output logic                     o_busy,
    output logic [DIV_W-1:0]         o_quot,
    output logic                     o_neg
);

    logic [DIV_W-1:0]         r_dvd;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_den;
    logic [$clog2(DIV_W)-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_neg;
    logic [DATA_W:0]          trial;
    logic                     ge;

    // restoring division, one quotient bit a cycle, quotient shifts into r_dvd
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_dvd  <= i_coef ? (DIV_W'(mag32(i_num)) << COEF_FRAC)
                             : (DIV_W'(mag32(i_num)) << VAL_FRAC);
            r_rem  <= '0;
            r_den  <= mag32(i_den);
            r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= ge ? DATA_W'(trial - {1'b0, r_den}) : trial[DATA_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == $clog2(DIV_W)'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;
    assign o_neg  = r_neg;

endmodule

// ----- sv/jls_dp.sv -----
module jls_dp import jls_pkg::*; #(
    parameter int MAX_N      = DEF_MAX_N,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [CNT_W-1:0]         i_n,
    input  logic [TOL_W-1:0]         i_tol,
    input  logic [ITER_W-1:0]        i_limit,
    input  logic [IDX_W-1:0]         i_ld_row,
    input  logic [COL_W-1:0]         i_ld_col,
    input  logic signed [DATA_W-1:0] i_ld_val,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_value,
    output logic [STAT_W-1:0]        o_res_status,
    output logic [ITER_W-1:0]        o_iter
);

    localparam int NCAP  = (MAX_N < RES_CAP) ? MAX_N : RES_CAP;
    localparam int IW    = (NCAP > 1) ? $clog2(NCAP) : 1;
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int VB    = (VALUE_BITS > DATA_W) ? DATA_W : VALUE_BITS;
    localparam logic signed [XSUM_W-1:0] SAT_HI = (XSUM_W'(1) <<< (VB - 1)) - XSUM_W'(1);
    localparam logic signed [XSUM_W-1:0] SAT_LO = -SAT_HI - XSUM_W'(1);

    logic signed [DATA_W-1:0] r_mat [DEPTH];
    logic signed [DATA_W-1:0] r_cm  [DEPTH];
    logic signed [DATA_W-1:0] r_rhs [NCAP];
    logic signed [D_W-1:0]    r_d   [NCAP];
    logic signed [DATA_W-1:0] r_est [2][NCAP];
    logic [IW-1:0]            r_perm [NCAP];

    logic signed [DATA_W-1:0] r_mat_rd;
    logic signed [DATA_W-1:0] r_c_rd;
    logic signed [DATA_W-1:0] r_x;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_diag;
    logic [SUM_W-1:0]         r_sum;
    logic [DATA_W-1:0]        r_dmag;
    logic [DATA_W-1:0]        r_bm;
    logic [IW-1:0]            r_best;
    logic [IW-1:0]            r_tmp;
    logic [MASK_W-1:0]        r_cur;
    logic [MASK_W-1:0]        r_mask0;
    logic                     r_zero;
    logic [DATA_W-1:0]        r_nx;
    logic [DATA_W-1:0]        r_np;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_bank;
    logic                     r_conv;
    logic                     r_lim;
    logic [STAT_W-1:0]        r_res_status;

    logic [IW-1:0]            row_i;
    logic [IW-1:0]            col_i;
    logic [IW-1:0]            perm_rd;
    logic [AW-1:0]            w_addr;
    logic [AW-1:0]            c_addr;
    logic [AW-1:0]            ld_addr;
    logic                     ld_row_ok;
    logic                     ld_rhs;
    logic                     ld_mat;
    logic                     mat_we;
    logic                     cm_we;
    logic signed [DATA_W-1:0] cm_wdata;
    logic [DATA_W-1:0]        rd_mag;
    logic                     div_start;
    logic                     div_coef;
    logic signed [DATA_W-1:0] div_num;
    logic                     div_busy;
    logic [DIV_W-1:0]         div_quot;
    logic                     div_neg;
    logic signed [XSUM_W-1:0] x_sum;
    logic signed [DATA_W-1:0] x_sat;
    logic [DATA_W-1:0]        x_mag;
    logic signed [DATA_W:0]   nrm_diff;
    logic [DATA_W:0]          nrm_delta;
    logic [ITER_W-1:0]        iter_n;
    logic [ITER_W-1:0]        limit_eff;
    logic                     conv_now;

    assign row_i   = i_cmd.row[IW-1:0];
    assign col_i   = i_cmd.col[IW-1:0];
    // one read of the row map per cycle: the swap reads the chosen row
    assign perm_rd = (i_cmd.op == OP_SW_B) ? r_perm[r_best] : r_perm[row_i];
    assign w_addr  = AW'(perm_rd) * AW'(MAX_N) + AW'(i_cmd.col);
    assign c_addr  = AW'(i_cmd.row) * AW'(MAX_N) + AW'(i_cmd.col);
    assign ld_addr = AW'(i_ld_row) * AW'(MAX_N) + AW'(i_ld_col);

    assign ld_row_ok = int'(i_ld_row) < MAX_N;
    assign ld_rhs    = ld_row_ok && (i_ld_col == i_n);
    assign ld_mat    = ld_row_ok && !ld_rhs && (int'(i_ld_col) < MAX_N);
    assign mat_we    = (i_cmd.op == OP_LOAD) && ld_mat;

    assign cm_we    = (i_cmd.op == OP_WR_C) || (i_cmd.op == OP_WR_CZ);
    assign cm_wdata = (i_cmd.op == OP_WR_CZ) ? '0
                    : (div_neg ? div_quot[DATA_W-1:0] : DATA_W'(-div_quot[DATA_W-1:0]));

    assign rd_mag = mag32(r_mat_rd);

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[ld_addr] <= i_ld_val;
        end
        r_mat_rd <= r_mat[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cm[c_addr] <= cm_wdata;
        end
        r_c_rd <= r_cm[c_addr];
    end

    assign div_start = (i_cmd.op == OP_DIV_C) || (i_cmd.op == OP_DIV_D);
    assign div_coef  = (i_cmd.op == OP_DIV_C);
    assign div_num   = div_coef ? r_mat_rd : r_rhs[perm_rd];

    jls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_diag),
        .i_coef  (div_coef),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_neg   (div_neg)
    );

    // new estimate: d + floor(acc / 2^30), saturated
    assign x_sum = XSUM_W'(r_d[row_i]) + XSUM_W'(r_acc >>> COEF_FRAC);
    assign x_sat = (x_sum > SAT_HI) ? DATA_W'(SAT_HI)
                 : ((x_sum < SAT_LO) ? DATA_W'(SAT_LO) : DATA_W'(x_sum));
    assign x_mag = mag32(x_sat);

    assign nrm_diff  = $signed({1'b0, r_nx}) - $signed({1'b0, r_np});
    assign nrm_delta = nrm_diff[DATA_W] ? (DATA_W + 1)'(-nrm_diff) : nrm_diff;
    assign conv_now  = nrm_delta <= (DATA_W + 1)'(i_tol);
    assign iter_n    = r_iter + 1'b1;
    assign limit_eff = (i_limit == '0) ? ITER_W'(1) : i_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_mask0      <= '0;
            r_zero       <= 1'b0;
            r_iter       <= '0;
            r_bank       <= 1'b0;
            r_conv       <= 1'b0;
            r_lim        <= 1'b0;
            r_res_status <= RES_CONVERGED;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    if (ld_rhs) begin
                        r_rhs[i_ld_row[IW-1:0]] <= i_ld_val;
                    end
                end
                OP_INIT: begin
                    for (int k = 0; k < NCAP; k++) begin
                        r_perm[k] <= IW'(k);
                    end
                    r_cur   <= '0;
                    r_mask0 <= '0;
                    r_zero  <= 1'b0;
                    r_sum   <= '0;
                    r_iter  <= '0;
                end
                OP_DOM_ACC: begin
                    if (i_cmd.row == i_cmd.col) begin
                        r_dmag <= rd_mag;
                    end else begin
                        r_sum <= r_sum + SUM_W'(rd_mag);
                    end
                end
                OP_DOM_ROW: begin
                    if (r_sum > SUM_W'(r_dmag)) begin
                        r_cur[i_cmd.row] <= 1'b1;
                    end
                    if (r_dmag == '0) begin
                        r_zero <= 1'b1;
                    end
                    r_sum <= '0;
                end
                OP_SAVE_MASK: begin
                    r_mask0 <= r_cur;
                    r_cur   <= '0;
                    r_zero  <= 1'b0;
                end
                OP_SW_INIT: begin
                    r_bm   <= '0;
                    r_best <= row_i;
                end
                OP_SW_CMP: begin
                    if (r_mask0[i_cmd.row] && (rd_mag > r_bm)) begin
                        r_bm   <= rd_mag;
                        r_best <= row_i;
                    end
                end
                OP_SW_A: r_tmp <= r_perm[row_i];
                OP_SW_B: r_perm[row_i] <= perm_rd;
                OP_SW_C: r_perm[r_best] <= r_tmp;
                OP_DIAG: r_diag <= r_mat_rd;
                OP_WR_D: begin
                    r_d[row_i] <= div_neg ? D_W'(-div_quot[D_W-1:0]) : div_quot[D_W-1:0];
                end
                OP_IT_START: begin
                    for (int k = 0; k < NCAP; k++) begin
                        r_est[r_bank][k] <= '0;
                    end
                    r_nx   <= '0;
                    r_np   <= '0;
                    r_iter <= '0;
                    r_acc  <= '0;
                    r_conv <= 1'b0;
                    r_lim  <= 1'b0;
                end
                OP_IT_RD: r_x <= r_est[r_bank][col_i];
                OP_IT_MUL: r_prod <= r_c_rd * r_x;
                OP_IT_ACC: r_acc <= r_acc + ACC_W'(r_prod);
                OP_IT_ROW: begin
                    r_est[~r_bank][row_i] <= x_sat;
                    if (x_mag > r_nx) begin
                        r_nx <= x_mag;
                    end
                    r_acc <= '0;
                end
                OP_IT_END: begin
                    r_iter       <= iter_n;
                    r_conv       <= conv_now;
                    r_lim        <= iter_n >= limit_eff;
                    r_res_status <= conv_now ? RES_CONVERGED : RES_LIMIT;
                    r_np         <= r_nx;
                    r_nx         <= '0;
                    r_bank       <= ~r_bank;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.mask0     = r_mask0;
    assign o_status.fail      = r_cur != '0;
    assign o_status.zero_diag = r_zero;
    assign o_status.div_busy  = div_busy;
    assign o_status.conv      = r_conv;
    assign o_status.lim       = r_lim;

    assign o_value      = r_est[r_bank][row_i];
    assign o_res_status = r_res_status;
    assign o_iter       = r_iter;

endmodule

// ----- sv/jls_ctrl.sv -----
module jls_ctrl import jls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_type,
    input  logic             i_res_ready,
    input  logic [CNT_W-1:0] i_n,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic             o_req_ready,
    output logic             o_res_valid,
    output logic             o_res_last,
    output logic             o_nosol,
    output logic [IDX_W-1:0] o_index
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_pass, n_pass;
    logic [CNT_W-1:0] nm1;
    logic             last_i;
    logic             j_last;

    assign nm1    = i_n - 1'b1;
    assign last_i = r_i == nm1;
    assign j_last = r_j == nm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_pass      = r_pass;
        o_cmd.op    = OP_NONE;
        o_cmd.row   = r_i[IDX_W-1:0];
        o_cmd.col   = r_j[IDX_W-1:0];
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res_last  = 1'b0;
        o_nosol     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_INIT;
                        n_i      = '0;
                        n_j      = '0;
                        n_pass   = 1'b0;
                        n_state  = ST_DOM_RD;
                    end
                end
            end
            ST_DOM_RD: begin
                o_cmd.op = OP_RD_W;
                n_state  = ST_DOM_ACC;
            end
            ST_DOM_ACC: begin
                o_cmd.op = OP_DOM_ACC;
                if (j_last) begin
                    n_state = ST_DOM_ROW;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_DOM_RD;
                end
            end
            ST_DOM_ROW: begin
                o_cmd.op = OP_DOM_ROW;
                n_j      = '0;
                if (last_i) begin
                    n_state = ST_DOM_END;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_DOM_RD;
                end
            end
            ST_DOM_END: begin
                n_i = '0;
                n_j = '0;
                priority if (!r_pass && i_status.fail) begin
                    o_cmd.op = OP_SAVE_MASK;
                    n_pass   = 1'b1;
                    n_state  = ST_SW_SEL;
                end else if (i_status.fail || i_status.zero_diag) begin
                    n_state = ST_NOSOL;
                end else begin
                    n_state = ST_CF_DRD;
                end
            end
            ST_SW_SEL: begin
                priority if (r_i == i_n) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_DOM_RD;
                end else if (i_status.mask0[r_i[IDX_W-1:0]]) begin
                    o_cmd.op = OP_SW_INIT;
                    n_j      = r_i;
                    n_state  = ST_SW_RD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_SW_RD: begin
                // candidate row j, column i
                o_cmd.op  = OP_RD_W;
                o_cmd.row = r_j[IDX_W-1:0];
                o_cmd.col = r_i[IDX_W-1:0];
                n_state   = ST_SW_CMP;
            end
            ST_SW_CMP: begin
                o_cmd.op  = OP_SW_CMP;
                o_cmd.row = r_j[IDX_W-1:0];
                if (j_last) begin
                    n_state = ST_SW_A;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_SW_RD;
                end
            end
            ST_SW_A: begin
                o_cmd.op = OP_SW_A;
                n_state  = ST_SW_B;
            end
            ST_SW_B: begin
                o_cmd.op = OP_SW_B;
                n_state  = ST_SW_C;
            end
            ST_SW_C: begin
                o_cmd.op = OP_SW_C;
                n_i      = r_i + 1'b1;
                n_state  = ST_SW_SEL;
            end
            ST_CF_DRD: begin
                o_cmd.op  = OP_RD_W;
                o_cmd.col = r_i[IDX_W-1:0];
                n_state   = ST_CF_DIAG;
            end
            ST_CF_DIAG: begin
                o_cmd.op = OP_DIAG;
                n_j      = '0;
                n_state  = ST_CF_RD;
            end
            ST_CF_RD: begin
                if (r_j == r_i) begin
                    o_cmd.op = OP_WR_CZ;
                    if (j_last) begin
                        n_state = ST_CF_D;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    o_cmd.op = OP_RD_W;
                    n_state  = ST_CF_DIV;
                end
            end
            ST_CF_DIV: begin
                o_cmd.op = OP_DIV_C;
                n_state  = ST_CF_WAIT;
            end
            ST_CF_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_CF_WR;
                end
            end
            ST_CF_WR: begin
                o_cmd.op = OP_WR_C;
                if (j_last) begin
                    n_state = ST_CF_D;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_CF_RD;
                end
            end
            ST_CF_D: begin
                o_cmd.op = OP_DIV_D;
                n_state  = ST_CF_DWAIT;
            end
            ST_CF_DWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_CF_DWR;
                end
            end
            ST_CF_DWR: begin
                o_cmd.op = OP_WR_D;
                n_j      = '0;
                if (last_i) begin
                    n_state = ST_IT_INIT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_CF_DRD;
                end
            end
            ST_IT_INIT: begin
                o_cmd.op = OP_IT_START;
                n_i      = '0;
                n_j      = '0;
                n_state  = ST_IT_RD;
            end
            ST_IT_RD: begin
                o_cmd.op = OP_IT_RD;
                n_state  = ST_IT_MUL;
            end
            ST_IT_MUL: begin
                o_cmd.op = OP_IT_MUL;
                n_state  = ST_IT_ACC;
            end
            ST_IT_ACC: begin
                o_cmd.op = OP_IT_ACC;
                if (j_last) begin
                    n_state = ST_IT_ROW;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_IT_RD;
                end
            end
            ST_IT_ROW: begin
                o_cmd.op = OP_IT_ROW;
                n_j      = '0;
                if (last_i) begin
                    n_state = ST_IT_END;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_IT_RD;
                end
            end
            ST_IT_END: begin
                o_cmd.op = OP_IT_END;
                n_i      = '0;
                n_j      = '0;
                n_state  = ST_IT_CHK;
            end
            ST_IT_CHK: begin
                if (i_status.conv || i_status.lim) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_IT_RD;
                end
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                o_res_last  = last_i;
                if (i_res_ready) begin
                    if (last_i) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_NOSOL: begin
                o_res_valid = 1'b1;
                o_res_last  = 1'b1;
                o_nosol     = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_index = r_i[IDX_W-1:0];

endmodule

// ----- sv/jacobi_linear_solver.sv -----
// Jacobi solver for an n-by-n system in signed Q16.16.
// i_req carries words: req_type load writes one coefficient (column < n) or the
// right-hand side (column == n) as it is taken; req_type solve starts a run.
// o_res returns n words, one per unknown, the last flagged by last_result; a system
// non-dominant after row swaps, or with a zero diagonal, gives a single no-solution word.
// The user must write configuration (size_in_use, tolerance, iteration_limit) through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle, which it does not enforce.
// A run, all over the single matrix read port and one multiplier, has these steps:
//   dominance test, run twice when rows get swapped
//   row swaps
//   coefficients, from the 64-step divider
//   each iteration
// then one result word per cycle while the receiver takes them. A load is
// taken every cycle while idle; i_req.ready is low from the solve word until the last
// result is taken. A stalled receiver holds the current word steady.
// Reset puts the controller idle and restores the register defaults; the
// stores keep no contents that a run relies on without loading.
module jacobi_linear_solver import jls_pkg::*; #(
    parameter int MAX_N      = DEF_MAX_N,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOL_W-1:0]     i_cfg_data,
    jls_req_if.sink              i_req,
    jls_res_if.source            o_res
);

    localparam int NCAP = (MAX_N < RES_CAP) ? MAX_N : RES_CAP;

    logic [SIZE_W-1:0]        r_size;
    logic [TOL_W-1:0]         r_tol;
    logic [ITER_W-1:0]        r_limit;
    logic [CNT_W-1:0]         size_eff;
    t_cmd                     cmd;
    t_status                  dp_status;
    logic                     res_last;
    logic                     nosol;
    logic [IDX_W-1:0]         res_index;
    logic signed [DATA_W-1:0] dp_value;
    logic [STAT_W-1:0]        dp_res_status;
    logic [ITER_W-1:0]        dp_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RESET;
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SIZE) begin
                r_size <= i_cfg_data[SIZE_W-1:0];
            end else if (i_cfg_index == CFG_TOL) begin
                r_tol <= i_cfg_data;
            end else if (i_cfg_index == CFG_LIMIT) begin
                r_limit <= i_cfg_data[ITER_W-1:0];
            end
        end
    end

    assign size_eff = (r_size == '0) ? CNT_W'(1)
                    : ((int'(r_size) > NCAP) ? CNT_W'(NCAP) : r_size);

    jls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_res_ready (o_res.ready),
        .i_n         (size_eff),
        .i_status    (dp_status),
        .o_cmd       (cmd),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .o_res_last  (res_last),
        .o_nosol     (nosol),
        .o_index     (res_index)
    );

    jls_dp #(
        .MAX_N      (MAX_N),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_n          (size_eff),
        .i_tol        (r_tol),
        .i_limit      (r_limit),
        .i_ld_row     (i_req.row_index),
        .i_ld_col     (i_req.column_index),
        .i_ld_val     (i_req.coefficient),
        .o_status     (dp_status),
        .o_value      (dp_value),
        .o_res_status (dp_res_status),
        .o_iter       (dp_iter)
    );

    assign o_res.unknown_index   = nosol ? '0 : res_index;
    assign o_res.solution_value  = nosol ? '0 : dp_value;
    assign o_res.status          = nosol ? RES_NO_SOLUTION : dp_res_status;
    assign o_res.iteration_count = nosol ? '0 : dp_iter;
    assign o_res.last_result     = res_last;

    // no new request while results are pending
    a_no_req_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("request taken while results pending");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_result) |=> i_req.ready)
        else $error("block not idle after last word");

    a_nosol_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == RES_NO_SOLUTION)) |->
        (o_res.last_result && (o_res.unknown_index == '0)))
        else $error("no-solution word malformed");

    a_iter_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != RES_NO_SOLUTION)) |->
        (o_res.iteration_count != '0))
        else $error("solved word without iterations");

endmodule

// ----- tb/jacobi_linear_solver_test.sv -----
`timescale 1ns / 100ps

module jacobi_linear_solver_test;
    import jls_pkg::*;

    localparam int QUIET_LIMIT = 4000000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic [1:0]  st;
        logic [15:0] cnt;
        logic        last;
    } t_sol_word;

    typedef struct {
        logic [3:0]  r;
        logic [4:0]  c;
        logic [31:0] v;
    } t_load;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SIZE;
    logic [TOL_W-1:0]     i_cfg_data = '0;

    jls_req_if req();
    jls_res_if res();

    jacobi_linear_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req.sink),
        .o_res       (res.source)
    );

    always #2 i_clk = ~i_clk;

    // mirror of the block's stores and registers
    longint      coef_m[16][16];
    longint      rhs_m[16];
    longint      est_m[16];
    logic [4:0]  size_m = 5'd4;
    logic [30:0] tol_m = 31'd66;
    logic [15:0] lim_m = 16'd1000;

    t_sol_word   sol_q[$];
    t_sol_word   got_exp;
    int          errors = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    int          stall_pct = 0;
    int          quiet = 0;
    int          stall_ctr = 0;
    bit          hold_go = 0;

    initial begin
        req.valid = 1'b0;
        req.req_type = REQ_LOAD;
        req.row_index = '0;
        req.column_index = '0;
        req.coefficient = '0;
        res.ready = 1'b0;
    end

    function automatic int eff_n();
        int n;
        n = size_m;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint qdiv(longint num, longint den, int frac);
        longint unsigned q;
        q = (longint'(absv(num)) << frac) / longint'(absv(den));
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] weak_rows(longint a[16][16], int n);
        logic [15:0] m;
        longint s;
        m = '0;
        for (int i = 0; i < n; i++) begin
            s = 0;
            for (int j = 0; j < n; j++)
                if (j != i) s += absv(a[i][j]);
            if (s > absv(a[i][i])) m[i] = 1'b1;
        end
        return m;
    endfunction

    function automatic void track_load(logic [3:0] r, logic [4:0] c, logic [31:0] v);
        if (c == eff_n()) rhs_m[r] = longint'($signed(v));
        else if (c < 16) coef_m[r][c] = longint'($signed(v));
    endfunction

    function automatic void solve_system();
        longint      w[16][16];
        longint      cq[16][16];
        longint      b[16], d[16], x[16];
        longint      bm, t, nx, np, acc, delta;
        logic [15:0] m;
        int          n, best;
        int unsigned lim, iters;
        logic [1:0]  st;
        t_sol_word   s;
        n = eff_n();
        for (int i = 0; i < n; i++) begin
            b[i] = rhs_m[i];
            for (int j = 0; j < n; j++) w[i][j] = coef_m[i][j];
        end
        m = weak_rows(w, n);
        if (m != 0) begin
            for (int i = 0; i < n; i++) begin
                if (!m[i]) continue;
                best = i;
                bm = absv(w[i][i]);
                for (int j = i; j < n; j++)
                    if (m[j] && absv(w[j][i]) > bm) begin
                        bm = absv(w[j][i]);
                        best = j;
                    end
                for (int j = 0; j < n; j++) begin
                    t = w[i][j]; w[i][j] = w[best][j]; w[best][j] = t;
                end
                t = b[i]; b[i] = b[best]; b[best] = t;
            end
            m = weak_rows(w, n);
        end
        for (int i = 0; i < n; i++)
            if (m == 0 && w[i][i] == 0) m = 16'd1;
        if (m != 0) begin
            s = '{4'd0, 32'd0, RES_NO_SOLUTION, 16'd0, 1'b1};
            sol_q = {sol_q, s};
            return;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++)
                cq[i][j] = (j == i) ? 0 : -qdiv(w[i][j], w[i][i], COEF_FRAC);
            d[i] = qdiv(b[i], w[i][i], VAL_FRAC);
            est_m[i] = 0;
        end
        lim = (lim_m == 0) ? 1 : lim_m;
        iters = 0;
        while (1) begin
            nx = 0;
            np = 0;
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++) acc += cq[i][j] * est_m[j];
                x[i] = d[i] + (acc >>> COEF_FRAC);
                if (x[i] > SAT_HI) x[i] = SAT_HI;
                if (x[i] < SAT_LO) x[i] = SAT_LO;
            end
            for (int i = 0; i < n; i++) begin
                if (absv(x[i]) > nx) nx = absv(x[i]);
                if (absv(est_m[i]) > np) np = absv(est_m[i]);
                est_m[i] = x[i];
            end
            delta = absv(nx - np);
            iters++;
            if (delta <= longint'(tol_m)) begin
                st = RES_CONVERGED;
                break;
            end
            if (iters >= lim) begin
                st = RES_LIMIT;
                break;
            end
        end
        for (int i = 0; i < n; i++) begin
            s = '{i[3:0], est_m[i][31:0], st, iters[15:0], i == n - 1};
            sol_q = {sol_q, s};
        end
    endfunction

    // result side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            stall_ctr = 1500;
        end
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (stall_ctr > 0) begin
            stall_ctr--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (sol_q.size() == 0) begin
                $error("unexpected result word idx=%0d val=%h", res.unknown_index,
                       res.solution_value);
                errors++;
            end else begin
                got_exp = sol_q.pop_front();
                if (res.unknown_index !== got_exp.idx) begin
                    $error("unknown_index exp %0d got %0d", got_exp.idx, res.unknown_index);
                    errors++;
                end
                if (res.solution_value !== got_exp.val) begin
                    $error("solution_value exp %h got %h", got_exp.val, res.solution_value);
                    errors++;
                end
                if (res.status !== got_exp.st) begin
                    $error("status exp %0d got %0d", got_exp.st, res.status);
                    errors++;
                end
                if (res.iteration_count !== got_exp.cnt) begin
                    $error("iteration_count exp %0d got %0d", got_exp.cnt,
                           res.iteration_count);
                    errors++;
                end
                if (res.last_result !== got_exp.last) begin
                    $error("last_result exp %0d got %0d", got_exp.last, res.last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(logic rt, logic [3:0] r, logic [4:0] c, logic [31:0] v);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                req.valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.req_type <= rt;
        req.row_index <= r;
        req.column_index <= c;
        req.coefficient <= v;
        do @(posedge i_clk); while (!req.ready);
        items_sent++;
        if (rt == REQ_LOAD) track_load(r, c, v);
        else solve_system();
    endtask

    task automatic load_word(logic [3:0] r, logic [4:0] c, logic [31:0] v);
        send_word(REQ_LOAD, r, c, v);
    endtask

    task automatic start_solve();
        send_word(REQ_SOLVE, 4'($urandom), 5'($urandom), $urandom);
    endtask

    task automatic stop_sending();
        req.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (sol_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(int n, logic [30:0] tol, logic [15:0] lim);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SIZE;
        i_cfg_data <= 31'(n);
        @(posedge i_clk);
        i_cfg_index <= CFG_TOL;
        i_cfg_data <= tol;
        @(posedge i_clk);
        i_cfg_index <= CFG_LIMIT;
        i_cfg_data <= 31'(lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_m = 5'(n);
        tol_m = tol;
        lim_m = lim;
    endtask

    // kind 0: dominant, 1: dominant with rows rotated, 2: raw random matrix
    task automatic load_system(int n, int kind, int spread);
        t_load  words[$];
        t_load  tmp;
        int     k, dst;
        longint dg, off;
        repeat ($urandom_range(3)) load_word(4'($urandom), 5'($urandom_range(16)), $urandom);
        for (int i = 0; i < n; i++) begin
            dst = (kind == 1) ? (i + 1) % n : i;
            dg = $urandom_range(1 << 20, 1 << 12);
            for (int j = 0; j < n; j++) begin
                if (kind == 2) off = longint'($signed($urandom));
                else if (j == i) off = $urandom_range(1) ? dg : -dg;
                else begin
                    off = $urandom_range(int'(dg / (spread * n)));
                    if ($urandom_range(1)) off = -off;
                end
                tmp = '{4'(dst), 5'(j), off[31:0]};
                words = {words, tmp};
            end
            tmp = '{4'(dst), 5'(n),
                    $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 22))};
            words = {words, tmp};
        end
        for (int i = words.size() - 1; i > 0; i--) begin
            k = $urandom_range(i);
            tmp = words[i]; words[i] = words[k]; words[k] = tmp;
        end
        foreach (words[i]) load_word(words[i].r, words[i].c, words[i].v);
    endtask

    task automatic test_saturation();
        set_regs(1, 31'd66, 16'd1000);
        load_word(4'd0, 5'd0, 32'h0000_0001);
        load_word(4'd0, 5'd1, 32'h7fff_ffff);
        start_solve();
        load_word(4'd0, 5'd1, 32'h8000_0000);
        start_solve();
    endtask

    task automatic test_zero_row();
        set_regs(2, 31'd66, 16'd1000);
        load_word(4'd0, 5'd0, 32'd0);
        load_word(4'd0, 5'd1, 32'd0);
        load_word(4'd1, 5'd0, 32'd0);
        load_word(4'd1, 5'd1, 32'd0);
        load_word(4'd0, 5'd2, 32'h0001_0000);
        load_word(4'd1, 5'd2, 32'h0002_0000);
        // column 16 is neither rhs nor a stored column here
        load_word(4'd15, 5'd16, 32'h1234_5678);
        start_solve();
    endtask

    task automatic test_no_solution();
        load_word(4'd0, 5'd0, 32'h0001_0000);
        load_word(4'd0, 5'd1, 32'h0001_0000);
        load_word(4'd1, 5'd0, 32'h0001_0000);
        load_word(4'd1, 5'd1, 32'h0001_0000);
        start_solve();
    endtask

    task automatic test_row_swap();
        set_regs(2, 31'd66, 16'd1);
        load_word(4'd0, 5'd0, 32'h0001_0000);
        load_word(4'd0, 5'd1, 32'h0004_0000);
        load_word(4'd1, 5'd0, 32'hfffc_0000);
        load_word(4'd1, 5'd1, 32'h0001_0000);
        start_solve();
    endtask

    task automatic test_size_extremes();
        gap_max = 2;
        stall_pct = 20;
        set_regs(16, 31'h7fff_ffff, 16'd20);
        load_system(16, 0, 2);
        start_solve();
        set_regs(2, 31'd66, 16'hffff);
        load_system(2, 0, 4);
        start_solve();
    endtask

    task automatic test_backpressure();
        set_regs(3, 31'd66, 16'd300);
        gap_max = 0;
        stall_pct = 0;
        load_system(3, 0, 2);
        hold_go = 1;
        start_solve();
        // these loads stall at the input until the held results drain
        load_system(3, 0, 2);
        start_solve();
        wait_drained();
        load_system(3, 1, 2);
        start_solve();
    endtask

    task automatic test_random();
        int          n;
        logic [30:0] tol;
        logic [15:0] lim;
        while (items_sent < 380) begin
            n = $urandom_range(6, 1);
            case ($urandom_range(3))
                0: tol = 31'd0;
                1: tol = 31'd66;
                2: tol = 31'($urandom_range(1 << 16));
                default: tol = 31'h7fff_ffff;
            endcase
            case ($urandom_range(2))
                0: lim = 16'd1;
                1: lim = 16'd300;
                default: lim = 16'($urandom_range(500, 1));
            endcase
            gap_max = $urandom_range(4);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
            set_regs(n, tol, lim);
            repeat (2) begin
                load_system(n, ($urandom_range(9) < 7) ? 0 :
                               ($urandom_range(1) ? 1 : 2), $urandom_range(3, 1));
                start_solve();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_saturation();
        test_zero_row();
        test_no_solution();
        test_row_swap();
        test_size_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/jls_pkg.sv
sv/jls_req_if.sv
sv/jls_res_if.sv
sv/jls_div.sv
sv/jls_dp.sv
sv/jls_ctrl.sv
sv/jacobi_linear_solver.sv
tb/jacobi_linear_solver_test.sv
